// ----- hw/rtl/pod_pkg.sv -----
// Shared types and constants for the prefix opcode decoder.
// Used by pod_front, pod_queue, pod_back and prefix_opcode_decoder; no dependencies.
package pod_pkg;

  // Function codes (high nibble of a code byte)
  localparam logic [3:0] FUNC_JUMP    = 4'h0;
  localparam logic [3:0] FUNC_PFIX    = 4'h2;
  localparam logic [3:0] FUNC_NFIX    = 4'h6;
  localparam logic [3:0] FUNC_CALL    = 4'h9;
  localparam logic [3:0] FUNC_CJUMP   = 4'hA;
  localparam logic [3:0] FUNC_OPERATE = 4'hF;

  localparam logic [3:0]  NIBBLE_MASK  = 4'hF;
  localparam logic [17:0] OP_MARK      = 18'h10000;
  localparam logic [17:0] OP_NEG       = 18'h20000;
  localparam logic [31:0] POS_EXTRA_OP = 32'h0000_017C;
  localparam logic [7:0]  LEN_MAX      = 8'd255;

  // Known operation indices 0x00..0xFF, bit n set when index n is known
  localparam logic [255:0] POS_OPS = {
    32'h0FFF0000, 32'h00007DF2, 32'h0F010000, 32'h10000002,
    32'h43FEF738, 32'hFFFFFFFF, 32'hFFFFDE07, 32'hFFEDFFFF
  };
  localparam logic [255:0] NEG_OPS = {
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00003000,
    32'h00000000, 32'h0000F000, 32'h0001C010, 32'h800038FF
  };

  // One finished instruction, as handed from front to back
  typedef struct packed {
    logic [31:0] start_addr;
    logic [7:0]  length;
    logic [3:0]  func;
    logic [31:0] total;
    logic [31:0] last_addr;
  } insn_rec_t;

  // Decoded result as held in the output register
  typedef struct packed {
    logic [17:0] operation_id;
    logic [31:0] branch_target;
    logic [31:0] operand_value;
    logic [3:0]  func_code;
    logic [7:0]  insn_length;
    logic [31:0] insn_address;
  } insn_res_t;

endpackage

// ----- hw/rtl/prefix_opcode_decoder.sv -----
// Prefix opcode decoder, top level: front end, record queue and back end.
// Depends on pod_pkg, pod_front, pod_queue and pod_back.
//
// Takes one code byte per cycle. Prefix bytes (function 2 and 6) fold into a
// 32-bit accumulator and produce nothing; every other byte closes the
// instruction and yields one result transaction, registered in the record queue
// and then in the back end's output register, holding start address, length,
// function code, operand, branch target and operation id, with tuser flagging a
// known (1) or unknown (0) operate code. Sustained rate is one byte per cycle, set
// by the prefix fold in the front end; a stalled output backs up into the
// QueueDepth-entry record queue first, and only final bytes wait on it.
module prefix_opcode_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [7:0] code_byte, [39:8] byte_address
  input  logic [39:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] insn_address, [39:32] insn_length, [43:40] func_code,
  // [75:44] operand_value, [107:76] branch_target, [125:108] operation_id, zero pad
  output logic [127:0] m_axis_tdata_o,
  // [0] insn_valid
  output logic         m_axis_tuser_o
);

  pod_pkg::insn_rec_t fr_rec, q_rec;
  pod_pkg::insn_res_t res;
  logic fr_valid, fr_ready;
  logic q_valid, q_ready;

  pod_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_valid_i   (s_axis_tvalid_i),
    .byte_ready_o   (s_axis_tready_o),
    .code_byte_i    (s_axis_tdata_i[7:0]),
    .byte_address_i (s_axis_tdata_i[39:8]),
    .rec_valid_o    (fr_valid),
    .rec_ready_i    (fr_ready),
    .rec_o          (fr_rec)
  );

  pod_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_rec),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_rec)
  );

  pod_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_ready_o (q_ready),
    .rec_i       (q_rec),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res),
    .res_ok_o    (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, res};

endmodule

// ----- hw/rtl/pod_front.sv -----
// Front end: takes code bytes, folds prefixes into the accumulator and emits
// one instruction record per final byte. Depends on pod_pkg.
module pod_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  logic [7:0]          code_byte_i,
  input  logic [31:0]         byte_address_i,
  output logic                rec_valid_o,
  input  logic                rec_ready_i,
  output pod_pkg::insn_rec_t  rec_o
);

  logic [31:0] acc_q, acc_d;
  logic [31:0] start_q, start_d;
  logic [7:0]  count_q, count_d;

  logic [3:0]  func;
  logic [3:0]  oper;
  logic        is_prefix;
  logic        fire;
  logic [31:0] addend;
  logic [31:0] start_now;

  assign func      = code_byte_i[7:4];
  assign oper      = code_byte_i[3:0] & pod_pkg::NIBBLE_MASK;
  assign is_prefix = (func == pod_pkg::FUNC_PFIX) || (func == pod_pkg::FUNC_NFIX);

  // Prefix bytes need no queue space, final bytes do
  assign byte_ready_o = is_prefix || rec_ready_i;
  assign fire         = byte_valid_i && byte_ready_o;
  assign rec_valid_o  = byte_valid_i && !is_prefix;

  assign start_now = (count_q == 8'd0) ? byte_address_i : start_q;
  // negative prefix adds ~operand, i.e. -operand-1
  assign addend    = (func == pod_pkg::FUNC_PFIX) ? {28'd0, oper} : ~{28'd0, oper};

  always_comb begin
    rec_o.start_addr = start_now;
    rec_o.length     = (count_q < pod_pkg::LEN_MAX) ? count_q + 8'd1 : pod_pkg::LEN_MAX;
    rec_o.func       = func;
    rec_o.total      = acc_q + {28'd0, oper};
    rec_o.last_addr  = byte_address_i;
  end

  always_comb begin
    acc_d   = acc_q;
    start_d = start_q;
    count_d = count_q;
    if (fire) begin
      start_d = start_now;
      if (is_prefix) begin
        acc_d   = (acc_q + addend) << 4;
        count_d = (count_q < pod_pkg::LEN_MAX) ? count_q + 8'd1 : count_q;
      end else begin
        acc_d   = 32'd0;
        count_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 32'd0;
      start_q <= 32'd0;
      count_q <= 8'd0;
    end else begin
      acc_q   <= acc_d;
      start_q <= start_d;
      count_q <= count_d;
    end
  end

  // a final byte always leaves the fold cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !is_prefix |=> (count_q == 8'd0) && (acc_q == 32'd0))
    else $error("front: fold not cleared after final byte");

  // a prefix byte always raises the count unless saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_prefix |=> (count_q != 8'd0))
    else $error("front: prefix byte not counted");

  // records only leave on a final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> (func != pod_pkg::FUNC_PFIX) && (func != pod_pkg::FUNC_NFIX))
    else $error("front: prefix byte offered as record");

endmodule

// ----- hw/rtl/pod_queue.sv -----
// Short queue of instruction records between front and back end.
// Depends on pod_pkg for the record type.
module pod_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  pod_pkg::insn_rec_t  push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output pod_pkg::insn_rec_t  pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pod_pkg::insn_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue: occupancy beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue: push not counted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue: pointers apart while empty");

endmodule

// ----- hw/rtl/pod_back.sv -----
// Back end: computes branch target and operation id of each record and holds
// the result in the output register. Depends on pod_pkg.
module pod_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  output logic                rec_ready_o,
  input  pod_pkg::insn_rec_t  rec_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output pod_pkg::insn_res_t  res_o,
  output logic                res_ok_o
);

  logic               out_valid_q;
  pod_pkg::insn_res_t res_q, res_d;
  logic               ok_q, ok_d;
  logic               take;
  logic [31:0]        canon;
  logic               pos_known, neg_known;

  assign rec_ready_o = !out_valid_q || res_ready_i;
  assign take        = rec_valid_i && rec_ready_o;

  // canonical index of a negative total: complement above the low nibble
  assign canon     = {~rec_i.total[31:4], rec_i.total[3:0]};
  assign pos_known = ((rec_i.total[31:8] == 24'd0) && pod_pkg::POS_OPS[rec_i.total[7:0]])
                     || (rec_i.total == pod_pkg::POS_EXTRA_OP);
  assign neg_known = (canon[31:8] == 24'd0) && pod_pkg::NEG_OPS[canon[7:0]];

  always_comb begin
    res_d.insn_address  = rec_i.start_addr;
    res_d.insn_length   = rec_i.length;
    res_d.func_code     = rec_i.func;
    res_d.operand_value = rec_i.total;
    res_d.branch_target = 32'd0;
    res_d.operation_id  = 18'd0;
    ok_d                = 1'b1;
    case (rec_i.func) inside
      pod_pkg::FUNC_JUMP, pod_pkg::FUNC_CALL, pod_pkg::FUNC_CJUMP: begin
        res_d.branch_target = rec_i.last_addr + 32'd1 + rec_i.total;
      end
      pod_pkg::FUNC_OPERATE: begin
        // zero total counts as a positive operation
        if (!rec_i.total[31]) begin
          if (pos_known) begin
            res_d.operation_id = pod_pkg::OP_MARK | {2'b00, rec_i.total[15:0]};
          end else begin
            ok_d = 1'b0;
          end
        end else begin
          if (neg_known) begin
            res_d.operation_id = pod_pkg::OP_MARK | pod_pkg::OP_NEG | {10'd0, canon[7:0]};
          end else begin
            ok_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
      ok_q  <= ok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign res_ok_o    = ok_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !ok_q |-> res_q.func_code == pod_pkg::FUNC_OPERATE)
    else $error("back: invalid result on non-operate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.operation_id != 18'd0) |->
      (res_q.func_code == pod_pkg::FUNC_OPERATE) && res_q.operation_id[16])
    else $error("back: operation id outside operate");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.branch_target != 32'd0) |->
      (res_q.func_code == pod_pkg::FUNC_JUMP) || (res_q.func_code == pod_pkg::FUNC_CALL)
      || (res_q.func_code == pod_pkg::FUNC_CJUMP))
    else $error("back: branch target on non-branch");

endmodule
